FILE: rtl/radix_integer_to_ascii_unit_macros.svh
// Assertion macros shared by the radix integer-to-ASCII checker.
`ifndef RADIX_INTEGER_TO_ASCII_UNIT_MACROS_SVH
`define RADIX_INTEGER_TO_ASCII_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define RITOA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define RITOA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ritoa_pkg.sv
// Types, constants and helper functions for the radix integer-to-ASCII unit.
`timescale 1ns / 1ps
package ritoa_pkg;

   localparam int DIGIT_W   = 6;
   localparam int CHAR_W    = 7;
   localparam int RADIX_W   = 6;
   // Quotient bits resolved per divider cycle.
   localparam int STEP_BITS = 4;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [RADIX_W-1:0] radix_type;
   typedef logic [CHAR_W-1:0]  char_type;

   localparam radix_type RADIX_MIN   = 6'd2;
   localparam radix_type RADIX_MAX   = 6'd36;
   localparam radix_type RADIX_RESET = 6'd10;

   localparam digit_type DIGIT_TEN    = 6'd10;
   localparam char_type  ASCII_ZERO   = 7'd48;
   // 'a' minus ten, so that digit ten maps to 'a'.
   localparam char_type  ASCII_LETTER = 7'd87;

   typedef struct packed {
      logic done;
      logic quo_zero;
   } div_status_type;

   function automatic radix_type clamp_radix(radix_type r);
      radix_type c;
      if (r < RADIX_MIN) begin
         c = RADIX_MIN;
      end else if (r > RADIX_MAX) begin
         c = RADIX_MAX;
      end else begin
         c = r;
      end
      return c;
   endfunction

   function automatic char_type digit_to_ascii(digit_type d);
      char_type c;
      if (d < DIGIT_TEN) begin
         c = ASCII_ZERO + {1'b0, d};
      end else begin
         c = ASCII_LETTER + {1'b0, d};
      end
      return c;
   endfunction

endpackage

FILE: rtl/ritoa_divider.sv
// Iterative divider by a small radix, a few quotient bits per cycle.
`timescale 1ns / 1ps
module ritoa_divider #(
   parameter int VALUE_BITS = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [VALUE_BITS-1:0]     dividend,
   input  ritoa_pkg::radix_type      radix,
   output ritoa_pkg::div_status_type status,
   output logic [VALUE_BITS-1:0]     quotient,
   output ritoa_pkg::digit_type      remainder
);
   import ritoa_pkg::*;

   localparam int STEPS = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD   = STEPS * STEP_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic [PAD-1:0]   quo_ff, quo_in;
   digit_type        rem_ff, rem_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             done_ff, done_in;

   logic [PAD-1:0]   step_quo;
   logic [DIGIT_W:0] step_part;

   // Restoring division: the dividend shifts out at the top while quotient
   // bits shift in at the bottom. The partial remainder stays below the radix.
   always_comb begin
      step_quo  = quo_ff;
      step_part = {1'b0, rem_ff};
      for (int i = 0; i < STEP_BITS; i++) begin
         step_part = {step_part[DIGIT_W-1:0], step_quo[PAD-1]};
         step_quo  = {step_quo[PAD-2:0], 1'b0};
         if (step_part >= {1'b0, radix}) begin
            step_part   = step_part - {1'b0, radix};
            step_quo[0] = 1'b1;
         end
      end
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = PAD'(dividend);
         rem_in = '0;
         cnt_in = CNT_W'(STEPS);
      end else if (cnt_ff != '0) begin
         quo_in  = step_quo;
         rem_in  = step_part[DIGIT_W-1:0];
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign quotient        = quo_ff[VALUE_BITS-1:0];
   assign remainder       = rem_ff;
   assign status.done     = done_ff;
   assign status.quo_zero = (quo_ff == '0);

endmodule

FILE: rtl/ritoa_store.sv
// Digit memory: one write port and one registered read port.
`timescale 1ns / 1ps
module ritoa_store #(
   parameter int  MAX_DIGITS = 32,
   localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [IDX_W-1:0]     wr_addr,
   input  ritoa_pkg::digit_type wr_digit,
   input  logic [IDX_W-1:0]     rd_addr,
   output ritoa_pkg::digit_type rd_digit
);
   import ritoa_pkg::*;

   digit_type mem [MAX_DIGITS];
   digit_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_digit;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[rd_addr];
   end

   assign rd_digit = rd_ff;

endmodule

FILE: rtl/radix_integer_to_ascii_unit.sv
// Top level of the radix integer-to-ASCII unit: sequencer, radix register.
`timescale 1ns / 1ps
// Converts one unsigned value to its ASCII digit string in a programmable base.
// Input: raise start with req_value; the transaction is taken at a clock edge
// where start is high and busy is low. busy stays high until the last
// character has been shown.
// Output: each transaction's characters on rsp_digit_char, most significant
// first, each marked by a one-cycle rsp_valid strobe; rsp_last flags the final one.
// The receiver cannot stall, so every strobed character must be taken.
// Configuration: csr_we writes csr_wdata into the radix register (reset 10);
// values below 2 act as 2 and values above 36 act as 36. Write it only while
// busy is low.
// Sequence: each digit is one pass of the shared divider, which loads the dividend
// and then resolves quotient bits; the remainder is stored as the digit. Once the
// quotient reaches zero, the characters follow one per cycle from the first strobe,
// and busy drops in the cycle after the last strobe.
// Reset clears the sequencer and sets the radix to 10; no clearing pass.
module radix_integer_to_ascii_unit #(
   parameter int MAX_DIGITS = 32,
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_BITS-1:0]  req_value,
   output logic                   rsp_valid,
   output ritoa_pkg::char_type    rsp_digit_char,
   output logic                   rsp_last,
   input  logic                   csr_we,
   input  ritoa_pkg::radix_type   csr_wdata
);
   import ritoa_pkg::*;

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   radix_type        radix_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] ptr_ff, ptr_in;
   logic             pend_ff, pend_in;
   logic             last_ff, last_in;

   logic                  accept;
   logic                  div_start;
   logic [VALUE_BITS-1:0] div_dividend;
   div_status_type        div_status;
   logic [VALUE_BITS-1:0] div_quotient;
   digit_type             div_remainder;
   logic                  wr_en;
   logic [CNT_W-1:0]      count_after;
   digit_type             rd_digit;

   assign busy   = (state_ff != ST_IDLE) || pend_ff;
   assign accept = start && !busy;

   // Digits beyond the store depth are the most significant ones and are dropped.
   assign wr_en       = (state_ff == ST_DIV) && div_status.done &&
                        (count_ff < CNT_W'(MAX_DIGITS));
   assign count_after = wr_en ? count_ff + CNT_W'(1) : count_ff;

   assign div_start    = accept ||
                         ((state_ff == ST_DIV) && div_status.done && !div_status.quo_zero);
   assign div_dividend = (state_ff == ST_IDLE) ? req_value : div_quotient;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      ptr_in   = ptr_ff;
      pend_in  = 1'b0;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               count_in = count_after;
               if (div_status.quo_zero) begin
                  ptr_in   = IDX_W'(count_after - CNT_W'(1));
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            // The read issued now comes back registered, so the strobe is registered to match.
            pend_in = 1'b1;
            last_in = (ptr_ff == '0);
            if (ptr_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               ptr_in = ptr_ff - IDX_W'(1);
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
         radix_ff <= RADIX_RESET;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (csr_we) begin
            radix_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff  <= ptr_in;
      last_ff <= last_in;
   end

   ritoa_divider #(
      .VALUE_BITS (VALUE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .radix     (clamp_radix(radix_ff)),
      .status    (div_status),
      .quotient  (div_quotient),
      .remainder (div_remainder)
   );

   ritoa_store #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (count_ff[IDX_W-1:0]),
      .wr_digit (div_remainder),
      .rd_addr  (ptr_ff),
      .rd_digit (rd_digit)
   );

   assign rsp_valid      = pend_ff;
   assign rsp_last       = last_ff;
   assign rsp_digit_char = digit_to_ascii(rd_digit);

endmodule

FILE: rtl/ritoa_checker.sv
// Port-level checker for the radix integer-to-ASCII unit, with its bind.
`timescale 1ns / 1ps
`include "radix_integer_to_ascii_unit_macros.svh"
module ritoa_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input ritoa_pkg::char_type rsp_digit_char,
   input logic                rsp_last
);
   import ritoa_pkg::*;

   // A character is only ever shown as part of an accepted transaction.
   `RITOA_ASSERT_SAME(a_valid_while_busy, clock, reset, rsp_valid, busy, "strobe while not busy")

   `RITOA_ASSERT_NEXT(a_accept_sets_busy, clock, reset, start && !busy, busy, "accept without busy")

   // Nothing follows the final character of a number.
   `RITOA_ASSERT_NEXT(a_quiet_after_last, clock, reset, rsp_valid && rsp_last, !rsp_valid, "strobe after last")

   // The unit only frees up right after delivering its final character.
   `RITOA_ASSERT_SAME(a_idle_after_last, clock, reset, $fell(busy) && !$past(reset), $past(rsp_valid && rsp_last), "busy dropped early")

   `RITOA_ASSERT_SAME(a_char_range, clock, reset, rsp_valid, (rsp_digit_char >= 7'd48 && rsp_digit_char <= 7'd57) || (rsp_digit_char >= 7'd97 && rsp_digit_char <= 7'd122), "bad character")

endmodule

bind radix_integer_to_ascii_unit ritoa_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .rsp_valid      (rsp_valid),
   .rsp_digit_char (rsp_digit_char),
   .rsp_last       (rsp_last)
);

FILE: tb/radix_integer_to_ascii_unit_tb.sv
// Self-checking testbench for the radix integer-to-ASCII unit.
`timescale 1ns / 1ps
module radix_integer_to_ascii_unit_tb;
   import ritoa_pkg::*;

   localparam int VALUE_W        = 32;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 100;
   localparam int MAX_REPORTS    = 10;
   localparam int SEGMENTS       = 5;
   localparam int SEGMENT_ITEMS  = 29;

   typedef struct {
      char_type ch;
      logic     last;
   } char_item_t;

   typedef struct {
      radix_type          radix;
      logic [VALUE_W-1:0] value;
      string              text;
   } directed_row_t;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [VALUE_W-1:0] req_value = '0;
   logic               rsp_valid;
   char_type           rsp_digit_char;
   logic               rsp_last;
   logic               csr_we = 1'b0;
   radix_type          csr_wdata = '0;

   char_item_t    pending_chars[$];
   directed_row_t directed_rows[$];
   radix_type     radix_setting = RADIX_RESET;
   radix_type     current_radix = RADIX_RESET;
   string         pinned_text = "";
   int            sender_idle_pct = 0;
   int            failures = 0;
   int            idle_cycles = 0;
   logic          progress;
   char_item_t    head;

   always #5 clock = ~clock;

   radix_integer_to_ascii_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata)
   );

   // Register values outside 2..36 behave as the nearest legal base.
   function automatic int unsigned effective_base(input radix_type r);
      int unsigned b;
      b = 32'(r);
      if (b < 2) begin
         b = 2;
      end else if (b > 36) begin
         b = 36;
      end
      return b;
   endfunction

   function automatic void predict_digit_string(input logic [VALUE_W-1:0] value,
                                                input radix_type r);
      int unsigned base;
      logic [VALUE_W-1:0] quotient;
      int unsigned digits[$];
      int unsigned d;
      char_item_t item;
      base = effective_base(r);
      quotient = value;
      do begin
         digits.push_back(quotient % base);
         quotient = quotient / base;
      end while (quotient != 0);
      // Digits come out least significant first; characters go most significant first.
      for (int k = digits.size() - 1; k >= 0; k--) begin
         d = digits[k];
         item.ch = (d < 10) ? char_type'(8'd48 + d) : char_type'(8'd97 + d - 10);
         item.last = (k == 0);
         pending_chars.push_back(item);
      end
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value(input int unsigned base);
      longint unsigned p;
      int unsigned k;
      logic [VALUE_W-1:0] v;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: v = $urandom;
         4, 5: v = $urandom_range(0, base * base);
         6: begin
            // A power of the base or one less, where the digit count changes.
            p = 1;
            k = $urandom_range(1, 32);
            repeat (k) begin
               if (p * base <= 64'hFFFF_FFFF) begin
                  p = p * base;
               end
            end
            v = VALUE_W'(p - $urandom_range(0, 1));
         end
         7: v = '1 - $urandom_range(0, 3);
         8: v = VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
         default: v = $urandom >> $urandom_range(0, VALUE_W - 1);
      endcase
      return v;
   endfunction

   // Results are checked and transactions predicted at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (rsp_valid) begin
            progress = 1'b1;
            if (pending_chars.size() == 0) begin
               if (failures < MAX_REPORTS) begin
                  $display("ERROR: unexpected character 0x%h last %b", rsp_digit_char,
                           rsp_last);
               end
               failures++;
            end else begin
               head = pending_chars.pop_front();
               if (rsp_digit_char !== head.ch || rsp_last !== head.last) begin
                  if (failures < MAX_REPORTS) begin
                     $display("ERROR: expected char 0x%h last %b, got char 0x%h last %b",
                              head.ch, head.last, rsp_digit_char, rsp_last);
                  end
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            progress = 1'b1;
            if (pinned_text.len() != 0) begin
               for (int i = 0; i < pinned_text.len(); i++) begin
                  head.ch = char_type'(pinned_text[i]);
                  head.last = (i == pinned_text.len() - 1);
                  pending_chars.push_back(head);
               end
            end else begin
               predict_digit_string(req_value, radix_setting);
            end
         end
         if (csr_we) begin
            radix_setting = csr_wdata;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (busy || pending_chars.size() != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_radix(input radix_type r);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= r;
      @(negedge clock);
      csr_we <= 1'b0;
      current_radix = r;
   endtask

   // Returns at the rising edge where the transaction is taken.
   task automatic send_value(input logic [VALUE_W-1:0] v, input string text);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      pinned_text = text;
      req_value <= v;
      start <= 1'b1;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
   endtask

   task automatic add_row(input radix_type r, input logic [VALUE_W-1:0] v,
                          input string text);
      directed_row_t row;
      row.radix = r;
      row.value = v;
      row.text = text;
      directed_rows.push_back(row);
   endtask

   initial begin
      int idle_plan[3];
      radix_type r;
      idle_plan = '{29, 67, 0};

      // An empty string means the row is checked against the predictor.
      add_row(6'd10, 32'd0, "0");
      add_row(6'd10, 32'hFFFF_FFFF, "4294967295");
      add_row(6'd10, 32'd9, "9");
      add_row(6'd10, 32'd10, "10");
      add_row(6'd10, 32'h5555_5555, "");
      add_row(6'd10, 32'hAAAA_AAAA, "");
      add_row(6'd2, 32'd0, "0");
      add_row(6'd2, 32'hFFFF_FFFF, "11111111111111111111111111111111");
      add_row(6'd2, 32'h8000_0000, "");
      add_row(6'd16, 32'hFFFF_FFFF, "ffffffff");
      add_row(6'd16, 32'hDEAD_BEEF, "deadbeef");
      add_row(6'd36, 32'd35, "z");
      add_row(6'd36, 32'd36, "10");
      add_row(6'd36, 32'hFFFF_FFFF, "");
      add_row(6'd0, 32'd5, "101");
      add_row(6'd1, 32'd6, "110");
      add_row(6'd37, 32'd35, "z");
      add_row(6'd63, 32'd36, "10");
      add_row(6'd63, 32'hFFFF_FFFF, "");
      add_row(6'd8, 32'h1234_5678, "");
      add_row(6'd3, 32'hFFFF_FFFF, "");

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         if (directed_rows[i].radix != current_radix) begin
            write_radix(directed_rows[i].radix);
         end
         send_value(directed_rows[i].value, directed_rows[i].text);
      end

      for (int p = 0; p < 3; p++) begin
         sender_idle_pct = idle_plan[p];
         for (int s = 0; s < SEGMENTS; s++) begin
            if (s == 0) begin
               r = 6'd2;
            end else if (s == 1) begin
               r = 6'd36;
            end else begin
               r = radix_type'($urandom_range(0, 63));
            end
            write_radix(r);
            repeat (SEGMENT_ITEMS) begin
               send_value(pick_value(effective_base(r)), "");
            end
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (pending_chars.size() != 0) begin
         failures++;
      end
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
